/* rtl/core/edt_pkg.sv */
// shared types and constants of the event id dispatch table
package edt_pkg;

  // operation codes carried in the mode field
  typedef enum logic [1:0] {
    MODE_ATTACH = 2'd0,
    MODE_DETACH = 2'd1,
    MODE_SEND   = 2'd2,
    MODE_UNUSED = 2'd3
  } edt_mode_e;

  // result status codes
  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_MISS   = 2'd1,
    STATUS_BAD_ID = 2'd2
  } edt_status_e;

  // datapath action selected by a control word
  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_LOAD   = 3'd1,
    OP_MOD    = 3'd2,
    OP_PRIME  = 3'd3,
    OP_SCAN   = 3'd4,
    OP_FINISH = 3'd5
  } edt_op_e;

  // jump condition selected by a control word
  typedef enum logic [2:0] {
    C_NEVER     = 3'd0,
    C_ALWAYS    = 3'd1,
    C_NO_START  = 3'd2,
    C_BAD       = 3'd3,
    C_MOD_BUSY  = 3'd4,
    C_SCAN_MORE = 3'd5,
    C_OUT_FREE  = 3'd6
  } edt_cond_e;

  localparam int unsigned PC_W = 3;

  // program step addresses
  localparam logic [PC_W-1:0] S_IDLE   = 3'd0;
  localparam logic [PC_W-1:0] S_CHECK  = 3'd1;
  localparam logic [PC_W-1:0] S_MOD    = 3'd2;
  localparam logic [PC_W-1:0] S_PRIME  = 3'd3;
  localparam logic [PC_W-1:0] S_SCAN   = 3'd4;
  localparam logic [PC_W-1:0] S_FINISH = 3'd5;
  localparam logic [PC_W-1:0] S_HOLD   = 3'd6;

  typedef struct packed {
    edt_op_e         op;
    edt_cond_e       cond;
    logic [PC_W-1:0] target;
  } edt_uword_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic start;
    logic bad;
    logic mod_busy;
    logic scan_more;
    logic out_free;
  } edt_flags_t;

endpackage

/* rtl/core/edt_ucode_rom.sv */
// control program of the dispatch table sequencer
module edt_ucode_rom (
  input  logic [edt_pkg::PC_W-1:0] pc_i,
  output edt_pkg::edt_uword_t      uword_o
);

  always_comb begin
    case (pc_i)
      // wait for a beat and latch it
      edt_pkg::S_IDLE: uword_o = '{edt_pkg::OP_LOAD, edt_pkg::C_NO_START, edt_pkg::S_IDLE};
      // zero id or unused mode skips the search
      edt_pkg::S_CHECK: uword_o = '{edt_pkg::OP_NONE, edt_pkg::C_BAD, edt_pkg::S_FINISH};
      // one remainder bit per pass
      edt_pkg::S_MOD: uword_o = '{edt_pkg::OP_MOD, edt_pkg::C_MOD_BUSY, edt_pkg::S_MOD};
      // read the home slot
      edt_pkg::S_PRIME: uword_o = '{edt_pkg::OP_PRIME, edt_pkg::C_NEVER, edt_pkg::S_IDLE};
      // one slot per pass
      edt_pkg::S_SCAN: uword_o = '{edt_pkg::OP_SCAN, edt_pkg::C_SCAN_MORE, edt_pkg::S_SCAN};
      // commit once the output register is free
      edt_pkg::S_FINISH: uword_o = '{edt_pkg::OP_FINISH, edt_pkg::C_OUT_FREE, edt_pkg::S_IDLE};
      edt_pkg::S_HOLD: uword_o = '{edt_pkg::OP_NONE, edt_pkg::C_ALWAYS, edt_pkg::S_FINISH};
      default: uword_o = '{edt_pkg::OP_NONE, edt_pkg::C_ALWAYS, edt_pkg::S_IDLE};
    endcase
  end

endmodule

/* rtl/core/edt_sequencer.sv */
// step counter with conditional jumps over the control program
module edt_sequencer (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  edt_pkg::edt_flags_t  flags_i,
  output edt_pkg::edt_uword_t  uword_o
);

  logic [edt_pkg::PC_W-1:0] pc_q, pc_d;
  logic                     take;

  edt_ucode_rom u_rom (
    .pc_i    (pc_q),
    .uword_o (uword_o)
  );

  always_comb begin
    case (uword_o.cond)
      edt_pkg::C_NEVER:     take = 1'b0;
      edt_pkg::C_ALWAYS:    take = 1'b1;
      edt_pkg::C_NO_START:  take = !flags_i.start;
      edt_pkg::C_BAD:       take = flags_i.bad;
      edt_pkg::C_MOD_BUSY:  take = flags_i.mod_busy;
      edt_pkg::C_SCAN_MORE: take = flags_i.scan_more;
      edt_pkg::C_OUT_FREE:  take = flags_i.out_free;
      default:              take = 1'b0;
    endcase
    pc_d = take ? uword_o.target : pc_q + edt_pkg::PC_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= edt_pkg::S_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

/* rtl/core/edt_datapath.sv */
// remainder unit, slot store, probe scan and result register
module edt_datapath #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  edt_pkg::edt_uword_t uword_i,
  output edt_pkg::edt_flags_t flags_o,
  input  logic                cfg_we_i,
  input  logic [4:0]          cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          mode_i,
  input  logic [7:0]          event_id_i,
  input  logic [15:0]         handler_token_i,
  input  logic [15:0]         object_token_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          status_o,
  output logic [3:0]          slot_index_o,
  output logic [15:0]         out_handler_o,
  output logic [15:0]         out_object_o,
  output logic [7:0]          out_event_id_o
);

  localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  // configuration
  logic [4:0]       table_size_q;
  logic [8:0]       n9;
  logic [CNT_W-1:0] n;

  // latched beat
  edt_pkg::edt_mode_e mode_q;
  logic [7:0]         id_q;
  logic [15:0]        hnd_q, obj_q;

  // remainder unit
  logic [CNT_W-1:0] rem_q, rem_d;
  logic [CNT_W:0]   rem_sh;
  logic [2:0]       bit_q;

  // store
  logic [7:0]          key_mem [CAPACITY];
  logic [15:0]         hnd_mem [CAPACITY];
  logic [15:0]         obj_mem [CAPACITY];
  logic [CAPACITY-1:0] valid_q;
  logic [IDX_W-1:0]    rd_addr;
  logic                rd_valid_q;
  logic [7:0]          rd_key_q;
  logic [15:0]         rd_hnd_q, rd_obj_q;

  // scan
  logic [IDX_W-1:0] home, cur_q, ptr_q, hit_slot_q, emp_slot_q;
  logic [CNT_W-1:0] k_q;
  logic             hit_q, emp_q, hit_now, is_attach;
  logic [15:0]      tok_h_q, tok_o_q;

  // result
  logic                  accept, commit, out_free;
  edt_pkg::edt_status_e  res_status;
  logic [IDX_W-1:0]      res_slot;
  logic                  res_ok, wr_en, clr_en;
  logic [15:0]           res_h, res_o;
  logic                  out_valid_q;
  logic [1:0]            status_q;
  logic [3:0]            slot_q;
  logic [15:0]           out_h_q, out_o_q;
  logic [7:0]            out_id_q;

  function automatic logic [IDX_W-1:0] wrap_next(input logic [IDX_W-1:0] p,
                                                 input logic [CNT_W-1:0] lim);
    logic [8:0] nx;
    nx = 9'(p) + 9'd1;
    return (nx == 9'(lim)) ? '0 : IDX_W'(nx);
  endfunction

  // size in use, clamped to one and to the capacity
  always_comb begin
    n9 = {4'b0, table_size_q};
    if (n9 == 9'd0) n9 = 9'd1;
    if (n9 > 9'(CAPACITY)) n9 = 9'(CAPACITY);
  end
  assign n = CNT_W'(n9);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= 5'd16;
    end else if (cfg_we_i) begin
      table_size_q <= cfg_wdata_i;
    end
  end

  assign in_ready_o = (uword_i.op == edt_pkg::OP_LOAD);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign commit     = (uword_i.op == edt_pkg::OP_FINISH) && out_free;
  assign is_attach  = (mode_q == edt_pkg::MODE_ATTACH);

  // restoring remainder, msb first
  always_comb begin
    rem_sh = {rem_q, id_q[bit_q]};
    if (rem_sh >= {1'b0, n}) begin
      rem_d = CNT_W'(rem_sh - {1'b0, n});
    end else begin
      rem_d = CNT_W'(rem_sh);
    end
  end

  assign home    = IDX_W'(rem_q);
  assign rd_addr = (uword_i.op == edt_pkg::OP_PRIME) ? home : ptr_q;
  assign hit_now = (rd_valid_q && (rd_key_q == id_q)) ||
                   (is_attach && (k_q == '0) && !rd_valid_q);

  assign flags_o.start     = in_valid_i;
  assign flags_o.bad       = (id_q == 8'd0) || (mode_q == edt_pkg::MODE_UNUSED);
  assign flags_o.mod_busy  = (bit_q != 3'd0);
  assign flags_o.scan_more = !hit_now && (({1'b0, k_q} + (CNT_W+1)'(1)) < {1'b0, n});
  assign flags_o.out_free  = out_free;

  // beat, remainder and scan registers
  always_ff @(posedge clk_i) begin
    case (uword_i.op)
      edt_pkg::OP_LOAD: begin
        if (accept) begin
          mode_q <= edt_pkg::edt_mode_e'(mode_i);
          id_q   <= event_id_i;
          hnd_q  <= handler_token_i;
          obj_q  <= object_token_i;
          rem_q  <= '0;
          bit_q  <= 3'd7;
          hit_q  <= 1'b0;
          emp_q  <= 1'b0;
        end
      end
      edt_pkg::OP_MOD: begin
        rem_q <= rem_d;
        bit_q <= bit_q - 3'd1;
      end
      edt_pkg::OP_PRIME: begin
        cur_q <= home;
        ptr_q <= wrap_next(home, n);
        k_q   <= '0;
      end
      edt_pkg::OP_SCAN: begin
        if (hit_now) begin
          hit_q      <= 1'b1;
          hit_slot_q <= cur_q;
          tok_h_q    <= rd_hnd_q;
          tok_o_q    <= rd_obj_q;
        end else if (is_attach && !rd_valid_q && !emp_q) begin
          emp_q      <= 1'b1;
          emp_slot_q <= cur_q;
        end
        cur_q <= ptr_q;
        ptr_q <= wrap_next(ptr_q, n);
        k_q   <= k_q + CNT_W'(1);
      end
      default: ;
    endcase
  end

  // store read port, registered
  always_ff @(posedge clk_i) begin
    rd_valid_q <= valid_q[rd_addr];
    rd_key_q   <= key_mem[rd_addr];
    rd_hnd_q   <= hnd_mem[rd_addr];
    rd_obj_q   <= obj_mem[rd_addr];
  end

  // outcome of the finished search
  always_comb begin
    res_status = edt_pkg::STATUS_MISS;
    res_ok     = 1'b0;
    res_slot   = hit_slot_q;
    res_h      = 16'd0;
    res_o      = 16'd0;
    wr_en      = 1'b0;
    clr_en     = 1'b0;
    if (id_q == 8'd0) begin
      res_status = edt_pkg::STATUS_BAD_ID;
    end else begin
      case (mode_q)
        edt_pkg::MODE_ATTACH: begin
          if (hit_q) begin
            res_ok = 1'b1;
            wr_en  = 1'b1;
          end else if (emp_q) begin
            res_ok   = 1'b1;
            wr_en    = 1'b1;
            res_slot = emp_slot_q;
          end
        end
        edt_pkg::MODE_DETACH: begin
          if (hit_q) begin
            res_ok = 1'b1;
            clr_en = 1'b1;
          end
        end
        edt_pkg::MODE_SEND: begin
          if (hit_q) begin
            res_ok = 1'b1;
            res_h  = tok_h_q;
            res_o  = tok_o_q;
          end
        end
        default: ;
      endcase
      if (res_ok) res_status = edt_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit && wr_en) begin
      key_mem[res_slot] <= id_q;
      hnd_mem[res_slot] <= hnd_q;
      obj_mem[res_slot] <= obj_q;
    end
  end

  // per slot occupancy, a cleared slot reads as empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (commit && wr_en) begin
      valid_q[res_slot] <= 1'b1;
    end else if (commit && clr_en) begin
      valid_q[res_slot] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (commit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (commit) begin
      status_q <= res_status;
      slot_q   <= res_ok ? 4'(res_slot) : 4'd0;
      out_h_q  <= res_h;
      out_o_q  <= res_o;
      out_id_q <= id_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign slot_index_o   = slot_q;
  assign out_handler_o  = out_h_q;
  assign out_object_o   = out_o_q;
  assign out_event_id_o = out_id_q;

endmodule

/* rtl/core/event_id_dispatch_table_top.sv */
// top level of the event id dispatch table
// Keyed table of CAPACITY slots holding a handler token and an object token per 8-bit
// event id; id 0 is rejected in every mode. A beat picks attach, detach or send; the
// home slot is id modulo table_size and the search runs from home with wrap over the
// slots in use, taking the first match (attach also takes home when free, else the
// first free slot). Control is a seven-step microprogram: the block takes one beat at
// a time, and a beat is accepted, its id checked, the bit-serial remainder formed,
// the home slot read, the slots scanned (one slot per cycle through the registered
// store read port) and the result committed; a zero id or an unused mode skips to the
// commit. The result sits in an output register; the next beat is accepted while it
// waits, and the commit of that next beat holds until the register is taken. All
// slots read empty right after reset through per-slot occupancy bits, with no
// clearing pass. table_size must be written only while the block is idle; the block
// itself does not enforce it; 0 acts as 1 and values above CAPACITY act as CAPACITY.
module event_id_dispatch_table_top #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  // request beat
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  mode_i,
  input  logic [7:0]  event_id_i,
  input  logic [15:0] handler_token_i,
  input  logic [15:0] object_token_i,
  // result beat
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [3:0]  slot_index_o,
  output logic [15:0] out_handler_o,
  output logic [15:0] out_object_o,
  output logic [7:0]  out_event_id_o
);

  edt_pkg::edt_uword_t uword;
  edt_pkg::edt_flags_t flags;

  // program counter and control store
  edt_sequencer u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .uword_o (uword)
  );

  // remainder, slot store, scan and output register
  edt_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .uword_i         (uword),
    .flags_o         (flags),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .mode_i          (mode_i),
    .event_id_i      (event_id_i),
    .handler_token_i (handler_token_i),
    .object_token_i  (object_token_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .slot_index_o    (slot_index_o),
    .out_handler_o   (out_handler_o),
    .out_object_o    (out_object_o),
    .out_event_id_o  (out_event_id_o)
  );

endmodule
